// File: sv/icov_pkg.sv
// icov_pkg: shared widths, payload structs and the icosahedron corner table
// used by the icosphere vertex generator and its root and divider pipelines
// depends on nothing
package icov_pkg;

  localparam int LEVEL_W = 7;
  localparam int STRIP_W = 3;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 8;
  localparam int IDX_W   = 16;
  localparam int COORD_W = 16;

  // corner coordinates in q20, differences, products and magnitudes
  localparam int CRN_W  = 22;
  localparam int DIFF_W = 23;
  localparam int P_W    = 31;
  localparam int MAG_W  = 30;
  localparam int SQ_W   = 60;
  localparam int N2_W   = 62;
  localparam int ROOT_W = 31;

  localparam int FIX_ONE = 1048576;
  localparam int FIX_PHI = 1696632;

  localparam int NUM_STRIPS = 5;
  localparam logic [3:0] RING_SOUTH = 4'd5;
  localparam logic [3:0] NORTH_POLE = 4'd10;
  localparam logic [3:0] SOUTH_POLE = 4'd11;

  localparam logic [CRN_W-1:0] K_ZERO = '0;
  localparam logic [CRN_W-1:0] K_ONE  = CRN_W'(FIX_ONE);
  localparam logic [CRN_W-1:0] K_NONE = CRN_W'(-FIX_ONE);
  localparam logic [CRN_W-1:0] K_PHI  = CRN_W'(FIX_PHI);
  localparam logic [CRN_W-1:0] K_NPHI = CRN_W'(-FIX_PHI);

  typedef logic [2:0][CRN_W-1:0] corner_t;

  typedef struct packed {
    logic [STRIP_W-1:0] strip_number;
    logic [COL_W-1:0]   column_position;
    logic [ROW_W-1:0]   row_position;
  } icov_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      bad_position;
  } icov_out_t;

  // travels alongside the square root
  typedef struct packed {
    logic [IDX_W-1:0]      index;
    logic                  bad;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } icov_rside_t;

  // travels alongside the dividers
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             bad;
    logic [2:0]       neg;
    logic             zero;
  } icov_dside_t;

  // element 0 is x, 1 is y, 2 is z
  function automatic corner_t corner_at(input logic [3:0] n);
    corner_t r;
    r = '0;
    case (n)
      4'd0: begin r[0] = K_ZERO; r[1] = K_NONE; r[2] = K_PHI;  end
      4'd1: begin r[0] = K_PHI;  r[1] = K_ZERO; r[2] = K_ONE;  end
      4'd2: begin r[0] = K_ONE;  r[1] = K_PHI;  r[2] = K_ZERO; end
      4'd3: begin r[0] = K_NONE; r[1] = K_PHI;  r[2] = K_ZERO; end
      4'd4: begin r[0] = K_NPHI; r[1] = K_ZERO; r[2] = K_ONE;  end
      4'd5: begin r[0] = K_NONE; r[1] = K_NPHI; r[2] = K_ZERO; end
      4'd6: begin r[0] = K_ONE;  r[1] = K_NPHI; r[2] = K_ZERO; end
      4'd7: begin r[0] = K_PHI;  r[1] = K_ZERO; r[2] = K_NONE; end
      4'd8: begin r[0] = K_ZERO; r[1] = K_ONE;  r[2] = K_NPHI; end
      4'd9: begin r[0] = K_NPHI; r[1] = K_ZERO; r[2] = K_NONE; end
      NORTH_POLE: begin r[0] = K_ZERO; r[1] = K_ONE;  r[2] = K_PHI;  end
      SOUTH_POLE: begin r[0] = K_ZERO; r[1] = K_NONE; r[2] = K_NPHI; end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/icosphere_vertex_generator.sv
// icosphere vertex generator: flat five-strip position to buffer index and unit-sphere point
// one vertex per cycle sustained while no result waits at the output
// the pipeline length is set by the square root (one bit per stage) and the dividers
// (one quotient bit per stage); the whole pipeline holds while a result waits at the output
// synchronous reset clears the valid bits and sets the level register to 1
module icosphere_vertex_generator #(
  parameter int COORD_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [icov_pkg::LEVEL_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  icov_pkg::icov_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output icov_pkg::icov_out_t                 out_data
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int Q_W    = F + 1;
  localparam int LW     = icov_pkg::LEVEL_W;
  localparam int P_W    = icov_pkg::P_W;
  localparam int MAG_W  = icov_pkg::MAG_W;
  localparam int SQ_W   = icov_pkg::SQ_W;
  localparam int N2_W   = icov_pkg::N2_W;
  localparam int DIFF_W = icov_pkg::DIFF_W;
  // seven front stages, the root, the divider with its numerator stage, the output register
  localparam int DEPTH  = 7 + icov_pkg::ROOT_W + (F + 2) + 1;
  localparam logic [Q_W-1:0] Q_LIM = Q_W'(1) << F;
  localparam logic [Q_W-1:0] Q_MAX = Q_LIM - Q_W'(1);

  // configuration register, level zero behaves as one
  logic [LW-1:0] level;
  logic [LW-1:0] d_eff;

  assign cfg_ready = 1'b1;
  assign d_eff     = (level == '0) ? LW'(1) : level;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LW'(1);
    end else if (cfg_valid && cfg_ready) begin
      level <= cfg_data;
    end
  end

  // the whole pipeline moves together; it holds only while a result waits
  logic             adv;
  logic [DEPTH-1:0] vld;

  assign adv       = out_ready || !out_valid;
  assign in_ready  = adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // stage 1: strip wrap, bounds flag, first index product
  logic [2:0]     strip5;
  logic [2:0]     s1_strip;
  logic [6:0]     s1_col;
  logic [7:0]     s1_row;
  logic [LW-1:0]  s1_d;
  logic [9:0]     s1_dt;
  logic           s1_bad;

  always_comb begin
    case (in_data.strip_number)
      3'd5:    strip5 = 3'd0;
      3'd6:    strip5 = 3'd1;
      3'd7:    strip5 = 3'd2;
      default: strip5 = in_data.strip_number;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_strip <= strip5;
      s1_col   <= in_data.column_position;
      s1_row   <= in_data.row_position;
      s1_d     <= d_eff;
      s1_dt    <= 10'(d_eff) * 10'(strip5) + 10'(in_data.column_position);
      s1_bad   <= (in_data.column_position > d_eff) ||
                  (10'(in_data.row_position) > 10'(d_eff) * 10'd3);
    end
  end

  // stage 2: seam move, face case, corner picks and weights, buffer index
  logic [8:0]  row9, d9, two_d, d_col;
  logic        seam;
  logic [2:0]  strip_s, next_s;
  logic [6:0]  col_s;
  logic [3:0]  ca, cb, cc;
  logic [8:0]  w1, w2;
  logic [18:0] idx_prod;

  always_comb begin
    row9  = 9'(s1_row);
    d9    = 9'(s1_d);
    two_d = d9 << 1;
    seam  = (row9 >= two_d) && (s1_col == '0);
    if (seam) begin
      strip_s = (s1_strip == 3'd0) ? 3'(icov_pkg::NUM_STRIPS - 1) : s1_strip - 3'd1;
      col_s   = s1_d;
    end else begin
      strip_s = s1_strip;
      col_s   = s1_col;
    end
    next_s = (strip_s == 3'(icov_pkg::NUM_STRIPS - 1)) ? 3'd0 : strip_s + 3'd1;
    d_col  = d9 + 9'(col_s);
    if (row9 <= d9) begin
      // northern cap
      ca = 4'(strip_s);
      cb = icov_pkg::NORTH_POLE;
      cc = 4'(next_s);
      w1 = d9 - row9;
      w2 = 9'(col_s);
    end else if (row9 >= two_d) begin
      // southern cap
      ca = icov_pkg::RING_SOUTH + 4'(next_s);
      cb = icov_pkg::SOUTH_POLE;
      cc = icov_pkg::RING_SOUTH + 4'(strip_s);
      w1 = row9 - two_d;
      w2 = d9 - 9'(col_s);
    end else if (row9 <= d_col) begin
      // upper band face
      ca = 4'(next_s);
      cb = icov_pkg::RING_SOUTH + 4'(next_s);
      cc = 4'(strip_s);
      w1 = row9 - d9;
      w2 = d9 - 9'(col_s);
    end else begin
      // lower band face
      ca = icov_pkg::RING_SOUTH + 4'(strip_s);
      cb = icov_pkg::RING_SOUTH + 4'(next_s);
      cc = 4'(strip_s);
      w1 = 9'(col_s);
      w2 = two_d - row9;
    end
    idx_prod = (19'(d9) * 19'd3 + 19'd1) * 19'(s1_dt) + 19'(s1_row);
  end

  logic [3:0]    s2_a, s2_b, s2_c;
  logic [6:0]    s2_c1, s2_c2;
  logic [LW-1:0] s2_d;
  logic [15:0]   s2_index;
  logic          s2_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a     <= ca;
      s2_b     <= cb;
      s2_c     <= cc;
      s2_c1    <= w1[6:0];
      s2_c2    <= w2[6:0];
      s2_d     <= s1_d;
      s2_index <= idx_prod[15:0];
      s2_bad   <= s1_bad;
    end
  end

  // stage 3: corner lookup and edge vectors
  icov_pkg::corner_t va, vb, vc;
  assign va = icov_pkg::corner_at(s2_a);
  assign vb = icov_pkg::corner_at(s2_b);
  assign vc = icov_pkg::corner_at(s2_c);

  logic signed [DIFF_W-1:0] s3_v0 [3];
  logic signed [DIFF_W-1:0] s3_db [3];
  logic signed [DIFF_W-1:0] s3_dc [3];
  logic [6:0]    s3_c1, s3_c2;
  logic [LW-1:0] s3_d;
  logic [15:0]   s3_index;
  logic          s3_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_v0[k] <= DIFF_W'($signed(va[k]));
        s3_db[k] <= DIFF_W'($signed(vb[k])) - DIFF_W'($signed(va[k]));
        s3_dc[k] <= DIFF_W'($signed(vc[k])) - DIFF_W'($signed(va[k]));
      end
      s3_c1    <= s2_c1;
      s3_c2    <= s2_c2;
      s3_d     <= s2_d;
      s3_index <= s2_index;
      s3_bad   <= s2_bad;
    end
  end

  // stage 4: weight products
  logic signed [P_W-1:0] dw, c1w, c2w;
  assign dw  = $signed(P_W'(s3_d));
  assign c1w = $signed(P_W'(s3_c1));
  assign c2w = $signed(P_W'(s3_c2));

  logic signed [P_W-1:0] s4_pd [3];
  logic signed [P_W-1:0] s4_p1 [3];
  logic signed [P_W-1:0] s4_p2 [3];
  logic [15:0] s4_index;
  logic        s4_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s4_pd[k] <= dw  * P_W'(s3_v0[k]);
        s4_p1[k] <= c1w * P_W'(s3_db[k]);
        s4_p2[k] <= c2w * P_W'(s3_dc[k]);
      end
      s4_index <= s3_index;
      s4_bad   <= s3_bad;
    end
  end

  // stage 5: unnormalised point, split into sign and magnitude
  logic signed [P_W-1:0] pt [3];
  logic [P_W-1:0]        pabs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt[k]   = s4_pd[k] + s4_p1[k] + s4_p2[k];
      pabs[k] = pt[k][P_W-1] ? P_W'(-pt[k]) : P_W'(pt[k]);
    end
  end

  logic [2:0][MAG_W-1:0] s5_mag;
  logic [2:0]            s5_neg;
  logic [15:0]           s5_index;
  logic                  s5_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s5_mag[k] <= pabs[k][MAG_W-1:0];
        s5_neg[k] <= pt[k][P_W-1];
      end
      s5_index <= s4_index;
      s5_bad   <= s4_bad;
    end
  end

  // stage 6: squares
  logic [SQ_W-1:0] s6_sq [3];
  icov_pkg::icov_rside_t s6_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s6_sq[k] <= SQ_W'(s5_mag[k]) * SQ_W'(s5_mag[k]);
      end
      s6_side.index <= s5_index;
      s6_side.bad   <= s5_bad;
      s6_side.neg   <= s5_neg;
      s6_side.mag   <= s5_mag;
    end
  end

  // stage 7: squared length
  logic [N2_W-1:0]       s7_n2;
  icov_pkg::icov_rside_t s7_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_n2   <= N2_W'(s6_sq[0]) + N2_W'(s6_sq[1]) + N2_W'(s6_sq[2]);
      s7_side <= s6_side;
    end
  end

  // floor square root of the squared length
  logic [icov_pkg::ROOT_W-1:0] root;
  icov_pkg::icov_rside_t       root_side;

  icov_root u_root (
    .clk      (clk),
    .adv      (adv),
    .rad      (s7_n2),
    .side_in  (s7_side),
    .root     (root),
    .side_out (root_side)
  );

  // rounded quotients |p| * 2^F / r
  logic [2:0][Q_W-1:0]   quot;
  icov_pkg::icov_dside_t div_side;

  icov_div #(
    .FRAC_BITS (F)
  ) u_div (
    .clk      (clk),
    .adv      (adv),
    .root     (root),
    .side_in  (root_side),
    .quot     (quot),
    .side_out (div_side)
  );

  // output register: saturate, apply sign, clear for out-of-bounds or zero length
  logic [Q_W-1:0]     qs [3];
  logic [31:0]        cval [3];
  logic [2:0][15:0]   coord;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (div_side.neg[k]) begin
        qs[k]   = (quot[k] > Q_LIM) ? Q_LIM : quot[k];
        cval[k] = 32'd0 - 32'(qs[k]);
      end else begin
        qs[k]   = (quot[k] > Q_MAX) ? Q_MAX : quot[k];
        cval[k] = 32'(qs[k]);
      end
      coord[k] = (div_side.bad || div_side.zero) ? 16'd0 : cval[k][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.vertex_index <= div_side.index;
      out_data.coord_x      <= $signed(coord[0]);
      out_data.coord_y      <= $signed(coord[1]);
      out_data.coord_z      <= $signed(coord[2]);
      out_data.bad_position <= div_side.bad;
    end
  end

endmodule

// File: sv/icov_root.sv
// icov_root: pipelined integer square root, one result bit per stage
// depends on icov_pkg
module icov_root (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [icov_pkg::N2_W-1:0]  rad,
  input  icov_pkg::icov_rside_t      side_in,
  output logic [icov_pkg::ROOT_W-1:0] root,
  output icov_pkg::icov_rside_t      side_out
);

  localparam int RW = icov_pkg::ROOT_W;
  localparam int NW = icov_pkg::N2_W;

  logic [NW-1:0]          rem [0:RW-1];
  logic [RW-1:0]          rt  [0:RW];
  icov_pkg::icov_rside_t  sd  [0:RW];

  assign rem[0] = rad;
  assign rt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int B = RW - 1 - j;
    logic [NW:0] trial;
    logic        take;

    assign trial = ({1'b0, NW'(rt[j])} << (B + 1)) + ((NW + 1)'(1) << (2 * B));
    assign take  = ({1'b0, rem[j]} >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rt[j+1] <= take ? (rt[j] | (RW'(1) << B)) : rt[j];
        sd[j+1] <= sd[j];
      end
    end

    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[j+1] <= take ? (rem[j] - trial[NW-1:0]) : rem[j];
        end
      end
    end
  end

  assign root     = rt[RW];
  assign side_out = sd[RW];

endmodule

// File: sv/icov_div.sv
// icov_div: three restoring dividers in lockstep giving rounded |p| * 2^frac / r,
// one quotient bit per stage
// depends on icov_pkg
module icov_div #(
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [icov_pkg::ROOT_W-1:0]  root,
  input  icov_pkg::icov_rside_t        side_in,
  output logic [2:0][FRAC_BITS:0]      quot,
  output icov_pkg::icov_dside_t        side_out
);

  localparam int Q_W   = FRAC_BITS + 1;
  localparam int NUM_W = icov_pkg::MAG_W + FRAC_BITS + 1;
  localparam int RW    = icov_pkg::ROOT_W;

  logic [RW-1:0]         den [0:Q_W];
  icov_pkg::icov_dside_t ds  [0:Q_W];

  // numerator stage: magnitude scaled plus half the divisor for rounding
  always_ff @(posedge clk) begin
    if (adv) begin
      den[0]        <= root;
      ds[0].index   <= side_in.index;
      ds[0].bad     <= side_in.bad;
      ds[0].neg     <= side_in.neg;
      ds[0].zero    <= (root == '0);
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (adv) begin
        den[j+1] <= den[j];
        ds[j+1]  <= ds[j];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [NUM_W-1:0] rem [0:Q_W-1];
    logic [Q_W-1:0]   q   [0:Q_W];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[0] <= (NUM_W'(side_in.mag[k]) << FRAC_BITS) + NUM_W'(root >> 1);
      end
    end
    assign q[0] = '0;

    for (genvar j = 0; j < Q_W; j++) begin : g_bit
      localparam int B = FRAC_BITS - j;
      logic [NUM_W:0] trial;
      logic           take;

      assign trial = (NUM_W + 1)'(den[j]) << B;
      assign take  = ({1'b0, rem[j]} >= trial);

      always_ff @(posedge clk) begin
        if (adv) begin
          q[j+1] <= take ? (q[j] | (Q_W'(1) << B)) : q[j];
        end
      end

      if (j < Q_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            rem[j+1] <= take ? (rem[j] - trial[NUM_W-1:0]) : rem[j];
          end
        end
      end
    end

    assign quot[k] = q[Q_W];
  end

  assign side_out = ds[Q_W];

endmodule

// File: verif/tb_icosphere_vertex_generator.sv
// testbench for icosphere_vertex_generator: directed and random vertex positions
// against a behavioural predictor of index and unit-sphere point, random idling on both sides
// depends on icov_pkg and the icosphere_vertex_generator rtl
module tb_icosphere_vertex_generator;

  localparam int FRAC = 15;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [icov_pkg::LEVEL_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  icov_pkg::icov_in_t in_data;
  logic out_valid;
  logic out_ready;
  icov_pkg::icov_out_t out_data;

  // predictor copy of the level register
  logic [icov_pkg::LEVEL_W-1:0] level_shadow;
  icov_pkg::icov_out_t vertex_queue[$];
  int fail_count;
  int idle_cycles;
  bit calm;   // no idling in the closing part

  icosphere_vertex_generator #(.COORD_FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // corner coordinates in q20 written out independently of the package table
  function automatic longint corner_coord(input int n, input int k);
    longint o;
    longint f;
    o = 1048576;
    f = 1696632;
    case (n)
      0: return (k == 0) ? 0 : (k == 1) ? -o : f;
      1: return (k == 0) ? f : (k == 1) ? 0 : o;
      2: return (k == 0) ? o : (k == 1) ? f : 0;
      3: return (k == 0) ? -o : (k == 1) ? f : 0;
      4: return (k == 0) ? -f : (k == 1) ? 0 : o;
      5: return (k == 0) ? -o : (k == 1) ? -f : 0;
      6: return (k == 0) ? o : (k == 1) ? -f : 0;
      7: return (k == 0) ? f : (k == 1) ? 0 : -o;
      8: return (k == 0) ? 0 : (k == 1) ? o : -f;
      9: return (k == 0) ? -f : (k == 1) ? 0 : -o;
      10: return (k == 0) ? 0 : (k == 1) ? o : f;
      default: return (k == 0) ? 0 : (k == 1) ? -o : -f;
    endcase
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [icov_pkg::COORD_W-1:0] sphere_coord(input longint p,
                                                                input longint unsigned r);
    longint unsigned mag;
    longint unsigned lim;
    longint unsigned q;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    lim = 64'd1 << FRAC;
    q = ((mag << FRAC) + (r >> 1)) / r;
    if (p < 0) begin
      if (q > lim) q = lim;
      return icov_pkg::COORD_W'(0 - q);
    end
    if (q > lim - 1) q = lim - 1;
    return icov_pkg::COORD_W'(q);
  endfunction

  function automatic icov_pkg::icov_out_t vertex_of(input icov_pkg::icov_in_t v);
    icov_pkg::icov_out_t res;
    longint d, strip, col, row, nxt, c1, c2, v0, p;
    longint unsigned n2, mag, r;
    int a, b, c;
    d = (level_shadow == 0) ? 1 : level_shadow;
    strip = v.strip_number % icov_pkg::NUM_STRIPS;
    col = v.column_position;
    row = v.row_position;
    res = '0;
    res.vertex_index = icov_pkg::IDX_W'(row + (3 * d + 1) * (col + d * strip));
    res.bad_position = (col > d) || (row > 3 * d);
    if (res.bad_position) return res;
    // seam position folds back onto the previous strip
    if (row >= 2 * d && col == 0) begin
      strip = (strip + icov_pkg::NUM_STRIPS - 1) % icov_pkg::NUM_STRIPS;
      col = d;
    end
    nxt = (strip + 1) % icov_pkg::NUM_STRIPS;
    if (row <= d) begin
      a = strip; b = 10; c = nxt; c1 = d - row; c2 = col;
    end else if (row >= 2 * d) begin
      a = 5 + nxt; b = 11; c = 5 + strip; c1 = row - 2 * d; c2 = d - col;
    end else if (row <= d + col) begin
      a = nxt; b = 5 + nxt; c = strip; c1 = row - d; c2 = d - col;
    end else begin
      a = 5 + strip; b = 5 + nxt; c = strip; c1 = col; c2 = 2 * d - row;
    end
    n2 = 0;
    for (int k = 0; k < 3; k++) begin
      v0 = corner_coord(a, k);
      p = d * v0 + c1 * (corner_coord(b, k) - v0) + c2 * (corner_coord(c, k) - v0);
      mag = (p < 0) ? longint'(-p) : longint'(p);
      n2 += mag * mag;
    end
    r = floor_root(n2);
    if (r == 0) return res;
    for (int k = 0; k < 3; k++) begin
      v0 = corner_coord(a, k);
      p = d * v0 + c1 * (corner_coord(b, k) - v0) + c2 * (corner_coord(c, k) - v0);
      case (k)
        0: res.coord_x = sphere_coord(p, r);
        1: res.coord_y = sphere_coord(p, r);
        default: res.coord_z = sphere_coord(p, r);
      endcase
    end
    return res;
  endfunction

  // random gap with valid dropped, sometimes none
  task automatic maybe_gap();
    int n;
    if (calm || $urandom_range(3) != 0) return;
    n = $urandom_range(19, 1);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_vertex(input logic [2:0] s, input logic [6:0] c, input logic [7:0] r);
    icov_pkg::icov_in_t v;
    v.strip_number = s;
    v.column_position = c;
    v.row_position = r;
    maybe_gap();
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vertex_queue.push_back(vertex_of(v));
  endtask

  task automatic write_level(input logic [icov_pkg::LEVEL_W-1:0] lvl);
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    level_shadow = lvl;
  endtask

  // mostly in-bounds positions for the current level, a few out of bounds
  task automatic send_random(input int n);
    int d;
    for (int i = 0; i < n; i++) begin
      d = (level_shadow == 0) ? 1 : level_shadow;
      if ($urandom_range(9) == 0)
        send_vertex(3'($urandom), 7'($urandom), 8'($urandom));
      else
        send_vertex(3'($urandom_range(4)), 7'($urandom_range(d)),
                    8'($urandom_range(3 * d)));
    end
  endtask

  // poles, seam, face boundaries, wrapped strips and out of bounds at level 4
  task automatic test_directed();
    write_level(7'd4);
    send_vertex(3'd0, 7'd0, 8'd0);
    send_vertex(3'd4, 7'd4, 8'd12);
    send_vertex(3'd2, 7'd0, 8'd8);
    send_vertex(3'd0, 7'd0, 8'd10);
    send_vertex(3'd1, 7'd2, 8'd4);
    send_vertex(3'd1, 7'd2, 8'd6);
    send_vertex(3'd1, 7'd2, 8'd7);
    send_vertex(3'd3, 7'd1, 8'd5);
    send_vertex(3'd5, 7'd1, 8'd3);
    send_vertex(3'd7, 7'd4, 8'd9);
    send_vertex(3'd2, 7'd5, 8'd1);
    send_vertex(3'd2, 7'd1, 8'd13);
    send_vertex(3'd7, 7'd127, 8'd255);
    send_vertex(3'd0, 7'd0, 8'd255);
  endtask

  task automatic test_level_zero();
    write_level(7'd0);
    send_vertex(3'd1, 7'd1, 8'd2);
    send_vertex(3'd3, 7'd0, 8'd3);
    send_vertex(3'd0, 7'd2, 8'd0);
    send_random(40);
  endtask

  task automatic test_levels();
    write_level(7'd1);
    send_random(200);
    write_level(7'd64);
    send_vertex(3'd4, 7'd64, 8'd192);
    send_vertex(3'd0, 7'd0, 8'd128);
    send_random(300);
    write_level(7'd127);
    send_random(100);
    write_level(7'd9);
    send_random(400);
    write_level(7'd3);
    send_random(300);
    calm = 1'b1;
    write_level(7'd37);
    send_random(300);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    level_shadow = 7'd1;
    fail_count = 0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_level_zero();
    test_levels();
    in_valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_icosphere_vertex_generator OK");
    else
      $display("tb_icosphere_vertex_generator NOT OK");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(19, 1);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    icov_pkg::icov_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (vertex_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        want = vertex_queue.pop_front();
        if (out_data.vertex_index !== want.vertex_index) begin
          $display("%0t vertex_index expected %h actual %h", $time,
                   want.vertex_index, out_data.vertex_index);
          fail_count++;
        end
        if (out_data.coord_x !== want.coord_x) begin
          $display("%0t coord_x expected %h actual %h", $time, want.coord_x, out_data.coord_x);
          fail_count++;
        end
        if (out_data.coord_y !== want.coord_y) begin
          $display("%0t coord_y expected %h actual %h", $time, want.coord_y, out_data.coord_y);
          fail_count++;
        end
        if (out_data.coord_z !== want.coord_z) begin
          $display("%0t coord_z expected %h actual %h", $time, want.coord_z, out_data.coord_z);
          fail_count++;
        end
        if (out_data.bad_position !== want.bad_position) begin
          $display("%0t bad_position expected %b actual %b", $time,
                   want.bad_position, out_data.bad_position);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_icosphere_vertex_generator NOT OK");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
